// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define TTT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ttt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and constants of the traffic tracking table.
// ----------------------------------------------------------------------------
package ttt_pkg;

    localparam int ENTRIES_DEF = 8;
    localparam logic [15:0] EXPIRY_RST = 16'd5;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SWEEP = 2'd1,
        OP_COUNT = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STS_REJECTED = 3'd0,
        STS_UPDATED  = 3'd1,
        STS_FILLED   = 3'd2,
        STS_REPLACED = 3'd3,
        STS_SWEPT    = 3'd4,
        STS_COUNTED  = 3'd5,
        STS_READ     = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE,
        S_DONE
    } t_state;

    // One table entry
    typedef struct packed {
        logic [23:0] addr;
        logic [31:0] stamp;
        logic [63:0] rec;
    } t_entry;

    // Request payload
    typedef struct packed {
        t_op         operation;
        logic [23:0] object_address;
        logic [31:0] object_stamp;
        logic [31:0] now_time;
        logic [63:0] object_record;
        logic [2:0]  slot_index;
    } t_req;

    // Response payload
    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [3:0]  occupied_count;
        logic [23:0] out_address;
        logic [31:0] out_stamp;
        logic [63:0] out_record;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic issue;
        logic write;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic go_scan;
        logic last;
        logic is_add;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hw/rtl/ttt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface ttt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [23:0] object_address;
    logic [31:0] object_stamp;
    logic [31:0] now_time;
    logic [63:0] object_record;
    logic [2:0]  slot_index;

    modport source (
        output valid, operation, object_address, object_stamp, now_time,
               object_record, slot_index,
        input  ready
    );
    modport sink (
        input  valid, operation, object_address, object_stamp, now_time,
               object_record, slot_index,
        output ready
    );
endinterface

interface ttt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [3:0]  occupied_count;
    logic [23:0] out_address;
    logic [31:0] out_stamp;
    logic [63:0] out_record;

    modport source (
        output valid, status, slot, occupied_count, out_address, out_stamp,
               out_record,
        input  ready
    );
    modport sink (
        input  valid, status, slot, occupied_count, out_address, out_stamp,
               out_record,
        output ready
    );
endinterface

// ===== hw/rtl/ttt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_datapath
// Entry memory, valid bits, occupancy counter, scan trackers and the
// response register.
// ----------------------------------------------------------------------------
module ttt_datapath #(
    parameter int ENTRIES = ttt_pkg::ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ttt_pkg::t_req    i_req,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_wdata,
    input  ttt_pkg::t_dp_cmd i_cmd,
    output ttt_pkg::t_dp_sts o_sts,
    input  logic             i_rsp_ready,
    output logic             o_rsp_valid,
    output ttt_pkg::t_rsp    o_rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // Captured transaction
    ttt_pkg::t_op    r_op;
    logic [23:0]     r_addr;
    logic [31:0]     r_stamp;
    logic [31:0]     r_now;
    logic [63:0]     r_rec;
    logic [2:0]      r_idx;

    logic [15:0]     r_expiry;

    // Storage
    ttt_pkg::t_entry r_mem [ENTRIES];
    ttt_pkg::t_entry r_rd_data;
    logic [ENTRIES-1:0] r_valid;
    logic [CW-1:0]   r_count;

    // Scan pointers
    logic [IW-1:0]   r_scan_idx;
    logic            r_chk_en;
    logic [IW-1:0]   r_chk_idx;

    // Add trackers
    logic            r_match_fnd;
    logic [IW-1:0]   r_match_idx;
    logic            r_empty_fnd;
    logic [IW-1:0]   r_empty_idx;
    logic            r_exp_fnd;
    logic [IW-1:0]   r_old_idx;
    logic [31:0]     r_old_stamp;
    logic [IW-1:0]   r_target;
    ttt_pkg::t_status r_kind;

    logic            r_rsp_valid;
    ttt_pkg::t_rsp   r_rsp;

    logic [IW-1:0]   w_rd_addr;
    logic            w_chk_valid;
    logic [31:0]     w_age;
    logic            w_aged;
    logic            w_expired;
    logic            w_fill;
    logic [IW-1:0]   w_target;
    ttt_pkg::t_status w_kind;
    logic            w_in_range;
    logic            w_rd_ok;
    ttt_pkg::t_rsp   w_rsp;

    // Status toward the controller
    always_comb begin
        o_sts.go_scan  = ((i_req.operation == ttt_pkg::OP_ADD) &&
                          (i_req.object_address != 24'd0)) ||
                         (i_req.operation == ttt_pkg::OP_SWEEP) ||
                         (i_req.operation == ttt_pkg::OP_READ);
        o_sts.last     = (r_op == ttt_pkg::OP_READ) || (r_scan_idx == LAST_IDX);
        o_sts.is_add   = (r_op == ttt_pkg::OP_ADD);
        o_sts.out_free = !r_rsp_valid || i_rsp_ready;
    end

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_req.operation;
            r_addr  <= i_req.object_address;
            r_stamp <= i_req.object_stamp;
            r_now   <= i_req.now_time;
            r_rec   <= i_req.object_record;
            r_idx   <= i_req.slot_index;
        end
    end

    // Expiry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry <= ttt_pkg::EXPIRY_RST;
        end else if (i_cfg_we) begin
            r_expiry <= i_cfg_wdata;
        end
    end

    // Read address: the requested slot for a read, else the scan pointer
    assign w_rd_addr = (r_op == ttt_pkg::OP_READ) ? IW'(r_idx) : r_scan_idx;

    // Checks on the entry read back last cycle
    assign w_chk_valid = r_valid[r_chk_idx];
    assign w_age       = r_now - r_rd_data.stamp;
    assign w_aged      = w_age > {16'd0, r_expiry};
    assign w_expired   = (r_now > r_rd_data.stamp) && w_aged;

    // Add target: same address, then first empty, then victim
    always_comb begin
        w_fill = !r_match_fnd && r_empty_fnd;
        if (r_match_fnd) begin
            w_target = r_match_idx;
            w_kind   = ttt_pkg::STS_UPDATED;
        end else if (r_empty_fnd) begin
            w_target = r_empty_idx;
            w_kind   = ttt_pkg::STS_FILLED;
        end else begin
            w_target = r_old_idx;
            w_kind   = ttt_pkg::STS_REPLACED;
        end
    end

    // Entry memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[w_target] <= '{addr: r_addr, stamp: r_stamp, rec: r_rec};
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Scan pointer and check stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_chk_en   <= 1'b0;
            r_chk_idx  <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_scan_idx <= '0;
            end else if (i_cmd.issue) begin
                r_scan_idx <= r_scan_idx + IW'(1);
            end
            r_chk_en  <= i_cmd.issue && (r_op != ttt_pkg::OP_READ);
            r_chk_idx <= w_rd_addr;
        end
    end

    // Add trackers: first match, first empty, expired or oldest victim
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_fnd <= 1'b0;
            r_empty_fnd <= 1'b0;
            r_exp_fnd   <= 1'b0;
        end else if (i_cmd.capture) begin
            r_match_fnd <= 1'b0;
            r_empty_fnd <= 1'b0;
            r_exp_fnd   <= 1'b0;
        end else if (r_chk_en && (r_op == ttt_pkg::OP_ADD)) begin
            if (w_chk_valid && (r_rd_data.addr == r_addr) && !r_match_fnd) begin
                r_match_fnd <= 1'b1;
                r_match_idx <= r_chk_idx;
            end
            if (!w_chk_valid && !r_empty_fnd) begin
                r_empty_fnd <= 1'b1;
                r_empty_idx <= r_chk_idx;
            end
            if (r_chk_idx == '0) begin
                r_old_idx   <= '0;
                r_old_stamp <= r_rd_data.stamp;
            end else if (!r_exp_fnd) begin
                if (w_expired) begin
                    r_exp_fnd <= 1'b1;
                    r_old_idx <= r_chk_idx;
                end else if (r_rd_data.stamp < r_old_stamp) begin
                    r_old_idx   <= r_chk_idx;
                    r_old_stamp <= r_rd_data.stamp;
                end
            end
        end
    end

    // Valid bits and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.write) begin
            r_valid[w_target] <= 1'b1;
            if (w_fill) begin
                r_count <= r_count + CW'(1);
            end
        end else if (r_chk_en && (r_op == ttt_pkg::OP_SWEEP) && w_chk_valid && w_aged) begin
            r_valid[r_chk_idx] <= 1'b0;
            r_count            <= r_count - CW'(1);
        end
    end

    // Remember where the add landed
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_target <= w_target;
            r_kind   <= w_kind;
        end
    end

    // Response build
    assign w_in_range = int'(r_idx) < ENTRIES;
    assign w_rd_ok    = w_in_range && r_valid[IW'(r_idx)];

    always_comb begin
        w_rsp = '0;
        w_rsp.occupied_count = (int'(r_count) > 15) ? 4'd15 : 4'(r_count);
        case (r_op)
            ttt_pkg::OP_ADD: begin
                if (r_addr == 24'd0) begin
                    w_rsp.status = ttt_pkg::STS_REJECTED;
                end else begin
                    w_rsp.status = r_kind;
                    w_rsp.slot   = 3'(r_target);
                end
            end
            ttt_pkg::OP_SWEEP: w_rsp.status = ttt_pkg::STS_SWEPT;
            ttt_pkg::OP_COUNT: w_rsp.status = ttt_pkg::STS_COUNTED;
            ttt_pkg::OP_READ: begin
                w_rsp.status = ttt_pkg::STS_READ;
                w_rsp.slot   = r_idx;
                if (w_rd_ok) begin
                    w_rsp.out_address = r_rd_data.addr;
                    w_rsp.out_stamp   = r_rd_data.stamp;
                    w_rsp.out_record  = r_rd_data.rec;
                end
            end
            default: w_rsp.status = ttt_pkg::STS_REJECTED;
        endcase
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== hw/rtl/ttt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_ctrl
// Sequencer for accept, scan, write-back and response hand-off.
// ----------------------------------------------------------------------------
module ttt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  ttt_pkg::t_dp_sts i_sts,
    output ttt_pkg::t_dp_cmd o_cmd
);

    ttt_pkg::t_state r_state;
    ttt_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ttt_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_sts.go_scan ? ttt_pkg::S_SCAN : ttt_pkg::S_DONE;
                end
            end
            ttt_pkg::S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last) begin
                    n_state = ttt_pkg::S_DRAIN;
                end
            end
            // last entry is checked here
            ttt_pkg::S_DRAIN: begin
                n_state = i_sts.is_add ? ttt_pkg::S_WRITE : ttt_pkg::S_DONE;
            end
            ttt_pkg::S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state = ttt_pkg::S_DONE;
            end
            ttt_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ttt_pkg::S_IDLE;
                end
            end
            default: n_state = ttt_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/traffic_tracking_table.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// traffic_tracking_table
// Keyed table of tracked objects with expiry sweep and expired-or-oldest replacement.
//
//   channel   dir  handshake     payload
//   i_req     in   valid/ready   operation, address, stamps, record, slot
//   o_rsp     out  valid/ready   status, slot, count, read-back entry
//   i_cfg_*   in   write enable  expiry_time (16 bit)
//
// Add and sweep scan the entry memory's read port one entry per cycle;
// read fetches only the requested slot, count and rejected add skip the scan.
// Synchronous reset clears valid bits and occupancy at once; expiry is 5.
// One transaction at a time; a new one is taken while a response is held.
// A held response stalls hand-off of the next until o_rsp.ready.
// ----------------------------------------------------------------------------
module traffic_tracking_table #(
    parameter int ENTRIES = ttt_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttt_req_if.sink     i_req,
    ttt_rsp_if.source   o_rsp,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    ttt_pkg::t_req    w_req;
    ttt_pkg::t_rsp    w_rsp;
    ttt_pkg::t_dp_cmd w_cmd;
    ttt_pkg::t_dp_sts w_sts;
    logic             w_rsp_valid;

    // Request payload into a struct
    always_comb begin
        w_req.operation      = ttt_pkg::t_op'(i_req.operation);
        w_req.object_address = i_req.object_address;
        w_req.object_stamp   = i_req.object_stamp;
        w_req.now_time       = i_req.now_time;
        w_req.object_record  = i_req.object_record;
        w_req.slot_index     = i_req.slot_index;
    end

    ttt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ttt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (w_rsp_valid),
        .o_rsp       (w_rsp)
    );

    // Response outputs
    assign o_rsp.valid          = w_rsp_valid;
    assign o_rsp.status         = w_rsp.status;
    assign o_rsp.slot           = w_rsp.slot;
    assign o_rsp.occupied_count = w_rsp.occupied_count;
    assign o_rsp.out_address    = w_rsp.out_address;
    assign o_rsp.out_stamp      = w_rsp.out_stamp;
    assign o_rsp.out_record     = w_rsp.out_record;

    // Checks
    `TTT_ASSERT(a_one_at_a_time, (i_req.valid && i_req.ready) |=> !i_req.ready, "request taken while busy")
    `TTT_ASSERT(a_rsp_from_finish, $rose(o_rsp.valid) |-> $past(w_cmd.finish), "response without finish")
    `TTT_ASSERT(a_no_rd_on_wr, !(w_cmd.write && w_cmd.issue), "memory write during scan")
    `TTT_ASSERT(a_count_bound, o_rsp.valid |-> (int'(o_rsp.occupied_count) <= ENTRIES), "occupancy above table size")

endmodule

// ===== sim/traffic_tracking_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traffic_tracking_table_tb
// Self-checking bench for the tracked-object table. A software mirror of
// the table predicts every response, including update, fill, expiry and
// oldest-entry replacement, and the wrapping-age sweep. Directed corner
// transactions come first, then random traffic over several expiry
// settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module traffic_tracking_table_tb;
    import ttt_pkg::*;

    localparam int ENTRIES    = ENTRIES_DEF;
    localparam int POOL_SIZE  = 12;
    localparam int PHASES     = 5;
    localparam int PHASE_LEN  = 200;
    localparam int STALL_PCT  = 33;
    localparam int IDLE_LIMIT = 5000;

    // Mirror of the table contents; holds the responses still due
    class track_table_mirror;
        logic [23:0] ent_addr  [ENTRIES];
        logic [31:0] ent_stamp [ENTRIES];
        logic [63:0] ent_rec   [ENTRIES];
        logic [15:0] expiry;
        t_rsp        due_results[$];
        int          errors;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                ent_addr[i]  = '0;
                ent_stamp[i] = '0;
                ent_rec[i]   = '0;
            end
            expiry = EXPIRY_RST;
            errors = 0;
        endfunction

        // Apply one accepted request to the mirror and queue its response
        function void note_request(t_req r);
            t_rsp        e;
            int          target;
            int          n;
            bit          found;
            logic [31:0] smallest;
            e = '0;
            target = -1;
            case (r.operation)
                OP_ADD: begin
                    if (r.object_address == '0) begin
                        e.status = STS_REJECTED;
                    end else begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (target < 0 && ent_addr[i] == r.object_address) begin
                                target = i;
                                e.status = STS_UPDATED;
                            end
                        for (int i = 0; i < ENTRIES; i++)
                            if (target < 0 && ent_addr[i] == '0) begin
                                target = i;
                                e.status = STS_FILLED;
                            end
                        // full table: first expired in 1..N-1, else oldest
                        if (target < 0) begin
                            e.status = STS_REPLACED;
                            target = 0;
                            smallest = ent_stamp[0];
                            found = 1'b0;
                            for (int i = 1; i < ENTRIES; i++)
                                if (!found) begin
                                    if (ent_stamp[i] < smallest) begin
                                        target = i;
                                        smallest = ent_stamp[i];
                                    end
                                    if (r.now_time > ent_stamp[i] &&
                                        (r.now_time - ent_stamp[i]) > {16'd0, expiry}) begin
                                        target = i;
                                        found = 1'b1;
                                    end
                                end
                        end
                        ent_addr[target]  = r.object_address;
                        ent_stamp[target] = r.object_stamp;
                        ent_rec[target]   = r.object_record;
                        e.slot = 3'(target);
                    end
                end
                OP_SWEEP: begin
                    // age wraps modulo 2^32
                    for (int i = 0; i < ENTRIES; i++)
                        if (ent_addr[i] != '0 &&
                            (r.now_time - ent_stamp[i]) > {16'd0, expiry}) begin
                            ent_addr[i]  = '0;
                            ent_stamp[i] = '0;
                            ent_rec[i]   = '0;
                        end
                    e.status = STS_SWEPT;
                end
                OP_COUNT: begin
                    e.status = STS_COUNTED;
                end
                default: begin
                    e.status = STS_READ;
                    e.slot = r.slot_index;
                    if (int'(r.slot_index) < ENTRIES) begin
                        e.out_address = ent_addr[r.slot_index];
                        e.out_stamp   = ent_stamp[r.slot_index];
                        e.out_record  = ent_rec[r.slot_index];
                    end
                end
            endcase
            n = 0;
            for (int i = 0; i < ENTRIES; i++)
                if (ent_addr[i] != '0)
                    n++;
            e.occupied_count = (n > 15) ? 4'd15 : 4'(n);
            due_results.push_back(e);
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one accepted response with the oldest one due
        function void check_result(t_rsp got);
            t_rsp e;
            if (due_results.size() == 0) begin
                $display("%0t: response with none due, status expected none actual %h",
                         $time, got.status);
                errors++;
                return;
            end
            e = due_results.pop_front();
            compare_field("status", e.status, got.status);
            compare_field("slot", e.slot, got.slot);
            compare_field("occupied_count", e.occupied_count, got.occupied_count);
            compare_field("out_address", e.out_address, got.out_address);
            compare_field("out_stamp", e.out_stamp, got.out_stamp);
            compare_field("out_record", e.out_record, got.out_record);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        calm;
    logic [23:0] addr_pool [POOL_SIZE];
    logic [31:0] track_now;
    int          idle_cycles;

    track_table_mirror mirror;

    ttt_req_if req_if ();
    ttt_rsp_if rsp_if ();

    traffic_tracking_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Response sink: check accepted transactions, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            mirror.check_result(t_rsp'({rsp_if.status, rsp_if.slot, rsp_if.occupied_count,
                                        rsp_if.out_address, rsp_if.out_stamp,
                                        rsp_if.out_record}));
        rsp_if.ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // Watchdog: no transaction on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("traffic_tracking_table: mismatch");
            $finish;
        end
    end

    function automatic t_req mk(t_op op, logic [23:0] a, logic [31:0] s, logic [31:0] n,
                                logic [63:0] rec, logic [2:0] idx);
        t_req r;
        r.operation      = op;
        r.object_address = a;
        r.object_stamp   = s;
        r.now_time       = n;
        r.object_record  = rec;
        r.slot_index     = idx;
        return r;
    endfunction

    // Random request: mostly pooled keys and stamps near a drifting clock
    function t_req rand_item();
        t_req        r;
        int unsigned p;
        int unsigned span;
        span = mirror.expiry;
        p = $urandom_range(0, 99);
        r.operation = (p < 50) ? OP_ADD : (p < 62) ? OP_SWEEP : (p < 72) ? OP_COUNT : OP_READ;
        track_now += $urandom_range(0, span / 3 + 1);
        r.now_time = ($urandom_range(0, 99) < 3) ? $urandom : track_now;
        p = $urandom_range(0, 99);
        if (p < 5)
            r.object_address = '0;
        else if (p < 75)
            r.object_address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            r.object_address = 24'($urandom);
        p = $urandom_range(0, 99);
        if (p < 80)
            r.object_stamp = r.now_time - $urandom_range(0, 2 * span + 2);
        else if (p < 90)
            r.object_stamp = r.now_time + $urandom_range(0, 3);
        else
            r.object_stamp = $urandom;
        r.object_record = {$urandom, $urandom};
        r.slot_index    = 3'($urandom_range(0, 7));
        return r;
    endfunction

    // Offer one request; returns at the edge where it is accepted
    task send_item(input t_req r);
        while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.operation      <= r.operation;
        req_if.object_address <= r.object_address;
        req_if.object_stamp   <= r.object_stamp;
        req_if.now_time       <= r.now_time;
        req_if.object_record  <= r.object_record;
        req_if.slot_index     <= r.slot_index;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        mirror.note_request(r);
    endtask

    task wait_drained();
        req_if.valid <= 1'b0;
        while (mirror.due_results.size() != 0)
            @(posedge i_clk);
    endtask

    task write_expiry(input logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mirror.expiry = v;
    endtask

    initial begin
        mirror = new();
        req_if.valid          = 1'b0;
        req_if.operation      = '0;
        req_if.object_address = '0;
        req_if.object_stamp   = '0;
        req_if.now_time       = '0;
        req_if.object_record  = '0;
        req_if.slot_index     = '0;
        rsp_if.ready          = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = '0;
        i_rst_n               = 1'b0;
        calm                  = 1'b0;
        idle_cycles           = 0;
        track_now             = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = 24'($urandom_range(1, 24'hFFFFFF));
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, reject, update, fill, both replacement paths
        send_item(mk(OP_COUNT, '0, '0, '0, '0, 3'd0));
        send_item(mk(OP_READ, '0, '0, '0, '0, 3'd0));
        send_item(mk(OP_ADD, '0, 32'd50, 32'd100, '1, 3'd0));
        send_item(mk(OP_ADD, 24'hFFFFFF, 32'd100, 32'd100, '1, 3'd0));
        send_item(mk(OP_ADD, 24'h000001, 32'hFFFFFFFF, 32'd100, '0, 3'd7));
        send_item(mk(OP_ADD, 24'hFFFFFF, 32'd101, 32'd100, 64'hA5A5_5A5A_F00F_0FF0, 3'd0));
        for (int i = 0; i < 6; i++)
            send_item(mk(OP_ADD, 24'h10 + 24'(i), 32'd102 + 32'(i), 32'd108, 64'(i), 3'd0));
        send_item(mk(OP_COUNT, '0, '0, 32'd108, '0, 3'd0));
        // full: slot 2 has expired during the scan
        send_item(mk(OP_ADD, 24'h20, 32'd110, 32'd108, 64'h1, 3'd0));
        // full, none expired: slot 0 is the oldest
        send_item(mk(OP_ADD, 24'h21, 32'd200, 32'd108, 64'h2, 3'd0));
        send_item(mk(OP_ADD, 24'h22, 32'd103, 32'd50, 64'h3, 3'd0));
        send_item(mk(OP_ADD, 24'h12, 32'd103, 32'd50, 64'h4, 3'd0));
        // two equal oldest stamps: lower slot wins
        send_item(mk(OP_ADD, 24'h23, 32'd0, 32'd50, 64'h5, 3'd0));
        send_item(mk(OP_READ, '0, '0, '0, '0, 3'd7));
        send_item(mk(OP_READ, '0, '0, '0, '0, 3'd3));
        // stamps ahead of now count as very old
        send_item(mk(OP_SWEEP, '0, '0, 32'd3, '0, 3'd0));
        send_item(mk(OP_COUNT, '0, '0, '0, '0, 3'd0));
        send_item(mk(OP_READ, '0, '0, '0, '0, 3'd1));
        send_item(mk(OP_ADD, 24'h800000, 32'h80000000, 32'hFFFFFFFF, {$urandom, $urandom},
                     3'd0));
        send_item(mk(OP_SWEEP, '0, '0, 32'hFFFFFFFF, '0, 3'd0));

        // Random phases, one expiry setting each
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       write_expiry(16'd0);
                1:       write_expiry(16'hFFFF);
                2:       write_expiry(16'($urandom_range(2, 400)));
                3:       write_expiry(16'd1);
                default: write_expiry(EXPIRY_RST);
            endcase
            calm <= (ph == 2);
            track_now = (ph == PHASES - 1) ? 32'hFFFF_FF00 : $urandom;
            repeat (PHASE_LEN)
                send_item(rand_item());
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.due_results.size() == 0)
            $display("traffic_tracking_table: match");
        else
            $display("traffic_tracking_table: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ttt_pkg.sv
hw/rtl/ttt_if.sv
hw/rtl/ttt_datapath.sv
hw/rtl/ttt_ctrl.sv
hw/rtl/traffic_tracking_table.sv
sim/traffic_tracking_table_tb.sv
